// ===== sv/ffsr_pkg.sv =====
// Package for the fast float square root core: binary32 constants and the
// shared types. No dependencies.
package ffsr_pkg;

   localparam logic [31:0] SEED_MAGIC = 32'h5f375a86;
   localparam logic [31:0] ONE_HALF   = 32'h3f000000;
   localparam logic [31:0] THREE_HALF = 32'h3fc00000;
   localparam logic [31:0] CANON_NAN  = 32'h7fc00000;

   // Stages from request acceptance to the result register: two for the half
   // product, eight for each of three Newton steps and two for the final multiply.
   localparam int PIPE_DEPTH = 28;

   // Unpacked operand: special class flags plus a normalized significand.
   typedef struct packed {
      logic        sgn;
      logic        is_nan;
      logic        is_inf;
      logic        is_zero;
      logic signed [9:0] exp;
      logic [23:0] sig;
   } unp_type;

   function automatic unp_type unpack(input logic [31:0] b);
      unp_type u;
      logic [23:0] m;
      logic [4:0] lz;
      logic found;
      u.sgn = b[31];
      u.is_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      u.is_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      u.is_zero = (b[30:0] == 31'd0);
      if (b[30:23] != 8'd0) begin
         u.exp = 10'(b[30:23]) - 10'sd127;
         u.sig = {1'b1, b[22:0]};
      end else begin
         m = {1'b0, b[22:0]};
         lz = 5'd0;
         found = 1'b0;
         for (int i = 23; i >= 0; i--) begin
            if (!found && m[i]) begin
               found = 1'b1;
               lz = 5'(23 - i);
            end
         end
         u.sig = m << lz;
         u.exp = -10'sd126 - 10'(lz);
      end
      return u;
   endfunction

   // Round a positive magnitude sig (bit 47 or 46 leading) * 2^(exp) to binary32,
   // where the value is sig/2^46 * 2^exp.
   function automatic logic [31:0] round_pack(input logic sgn, input logic signed [10:0] e_in,
                                              input logic [47:0] p_in);
      logic [47:0] p;
      logic signed [10:0] e;
      logic [8:0] sh;
      logic [75:0] w;
      logic [24:0] keep;
      logic g, st;
      logic [25:0] r;
      logic [7:0] be;
      p = p_in;
      e = e_in;
      if (p[47]) begin
         e = e + 11'sd1;
      end else begin
         p = p << 1;
      end
      // value = p/2^47 * 2^e, p[47]=1
      be = 8'd0;
      if (e >= -11'sd126) begin
         sh = 9'd0;
      end else if (e < -11'sd152) begin
         sh = 9'd30;
      end else begin
         sh = 9'(-11'sd126 - e);
      end
      // The window keeps every bit of a shift up to 28 for the sticky bit.
      w = {p, 28'd0} >> sh;
      keep = {1'b0, w[75:52]};
      g = w[51];
      st = (w[50:0] != 51'd0);
      r = {1'b0, keep} + ((g && (st || keep[0])) ? 26'd1 : 26'd0);
      if (sh != 9'd0) begin
         // subnormal range: exponent field becomes 1 if rounding reached normal
         return {sgn, (r[23] ? 8'd1 : 8'd0), r[22:0]};
      end
      if (r[24]) begin
         r = r >> 1;
         e = e + 11'sd1;
      end
      if (e > 11'sd127) begin
         return {sgn, 8'hff, 23'd0};
      end
      be = 8'(e + 11'sd127);
      return {sgn, be, r[22:0]};
   endfunction

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] half;
      logic [31:0] y;
   } lane_type;

endpackage

// ===== sv/ffsr_fmul.sv =====
// Two-stage binary32 multiplier: unpack and 24x24 product, then round.
// Depends on ffsr_pkg.
module ffsr_fmul (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] p
);
   ffsr_pkg::unp_type ua, ub;
   logic [47:0] prod_ff, prod_in;
   logic signed [10:0] exp_ff, exp_in;
   logic sgn_ff, sgn_in;
   logic nan_ff, nan_in, inf_ff, inf_in, zero_ff, zero_in;
   logic [31:0] p_ff, p_in;

   always_comb begin
      ua = ffsr_pkg::unpack(a);
      ub = ffsr_pkg::unpack(b);
      sgn_in = ua.sgn ^ ub.sgn;
      nan_in = ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) || (ub.is_inf && ua.is_zero);
      inf_in = ua.is_inf || ub.is_inf;
      zero_in = ua.is_zero || ub.is_zero;
      prod_in = 48'(ua.sig) * 48'(ub.sig);
      exp_in = 11'(ua.exp) + 11'(ub.exp);
   end

   always_comb begin
      if (nan_ff) begin
         p_in = ffsr_pkg::CANON_NAN;
      end else if (inf_ff) begin
         p_in = {sgn_ff, 8'hff, 23'd0};
      end else if (zero_ff) begin
         p_in = {sgn_ff, 31'd0};
      end else begin
         p_in = ffsr_pkg::round_pack(sgn_ff, exp_ff, prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         exp_ff <= exp_in;
         sgn_ff <= sgn_in;
         nan_ff <= nan_in;
         inf_ff <= inf_in;
         zero_ff <= zero_in;
         p_ff <= p_in;
      end
   end
   assign p = p_ff;
endmodule

// ===== sv/ffsr_fsub.sv =====
// Two-stage binary32 subtraction 1.5 - q: align, then normalize and round.
// Depends on ffsr_pkg.
module ffsr_fsub (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] q,
   output logic [31:0] r
);
   ffsr_pkg::unp_type ua, ub;
   logic [31:0] r_ff, r_in, spec_ff, spec_in;
   logic spec_v_ff, spec_v_in;
   logic [79:0] mag_ff, mag_in;
   logic sgn_ff, sgn_in;
   logic signed [10:0] ebase_ff, ebase_in;
   logic [79:0] ma, mb;
   logic [10:0] d;
   logic [6:0] lz;
   logic found;
   logic [79:0] nm;

   always_comb begin
      ua = ffsr_pkg::unpack(ffsr_pkg::THREE_HALF);
      ub = ffsr_pkg::unpack(q);
      ub.sgn = ~ub.sgn;
      spec_v_in = ub.is_nan || ub.is_inf || ub.is_zero;
      spec_in = ub.is_nan ? ffsr_pkg::CANON_NAN :
                ub.is_inf ? {ub.sgn, 8'hff, 23'd0} : ffsr_pkg::THREE_HALF;
      ma = 80'd0;
      mb = 80'd0;
      sgn_in = 1'b0;
      // Sum on a fixed-point grid anchored at the larger exponent, 50 guard bits.
      if (ub.exp > ua.exp) begin
         ebase_in = 11'(ub.exp);
         d = 11'(ub.exp - ua.exp);
         mb = {6'd0, ub.sig, 50'd0};
         ma = (d > 11'd55) ? 80'd1 : ({6'd0, ua.sig, 50'd0} >> d);
      end else begin
         ebase_in = 11'(ua.exp);
         d = 11'(ua.exp - ub.exp);
         ma = {6'd0, ua.sig, 50'd0};
         mb = (d > 11'd55) ? 80'd1 : ({6'd0, ub.sig, 50'd0} >> d);
      end
      if (ub.sgn) begin
         if (mb > ma) begin
            mag_in = mb - ma;
            sgn_in = 1'b1;
         end else begin
            mag_in = ma - mb;
         end
      end else begin
         mag_in = ma + mb;
      end
   end

   always_comb begin
      lz = 7'd0;
      found = 1'b0;
      for (int i = 79; i >= 0; i--) begin
         if (!found && mag_ff[i]) begin
            found = 1'b1;
            lz = 7'(79 - i);
         end
      end
      nm = mag_ff << lz;
      if (spec_v_ff) begin
         r_in = spec_ff;
      end else if (!found) begin
         r_in = 32'd0;
      end else begin
         // leading bit at 79 equals 2^(ebase+6-lz)
         r_in = ffsr_pkg::round_pack(sgn_ff, ebase_ff + 11'sd5 - 11'(lz),
                                     {nm[79:33], (nm[32:0] != 33'd0)});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         sgn_ff <= sgn_in;
         ebase_ff <= ebase_in;
         spec_ff <= spec_in;
         spec_v_ff <= spec_v_in;
         r_ff <= r_in;
      end
   end
   assign r = r_ff;
endmodule

// ===== sv/ffsr_newton.sv =====
// One Newton step y*(1.5-(h*y)*y) as four chained float units, eight stages.
// Depends on ffsr_pkg, ffsr_fmul and ffsr_fsub.
module ffsr_newton (
   input  logic                 clock,
   input  logic                 en,
   input  ffsr_pkg::lane_type   lane_i,
   output ffsr_pkg::lane_type   lane_o
);
   logic [31:0] hy, q, r, yn;
   logic [31:0] xd_ff [8];
   logic [31:0] hd_ff [8];
   logic [31:0] yd_ff [6];

   ffsr_fmul u_m0 (.clock(clock), .en(en), .a(lane_i.half), .b(lane_i.y), .p(hy));
   ffsr_fmul u_m1 (.clock(clock), .en(en), .a(hy), .b(yd_ff[1]), .p(q));
   ffsr_fsub u_s0 (.clock(clock), .en(en), .q(q), .r(r));
   ffsr_fmul u_m2 (.clock(clock), .en(en), .a(yd_ff[5]), .b(r), .p(yn));

   always_ff @(posedge clock) begin
      if (en) begin
         xd_ff[0] <= lane_i.x;
         hd_ff[0] <= lane_i.half;
         yd_ff[0] <= lane_i.y;
         for (int i = 1; i < 8; i++) begin
            xd_ff[i] <= xd_ff[i-1];
            hd_ff[i] <= hd_ff[i-1];
         end
         for (int i = 1; i < 6; i++) begin
            yd_ff[i] <= yd_ff[i-1];
         end
      end
   end

   assign lane_o.x = xd_ff[7];
   assign lane_o.half = hd_ff[7];
   assign lane_o.y = yn;
endmodule

// ===== sv/fast_float_square_root_core.sv =====
// Top level of the fast float square root core: seed, three Newton steps, x*y.
// Depends on ffsr_pkg, ffsr_fmul and ffsr_newton.
//
//   channel | ports                       | direction
//   request | req_valid req_ready req_value_bits | in
//   result  | rsp_valid rsp_ready rsp_root_bits  | out
//
// A request passes, after acceptance, through a half-product stage pair,
// three Newton steps of eight stages each, and the final x*y multiply pair.
// One request is accepted every cycle unless the pipeline holds. The whole
// pipeline advances together and holds when the output register is full and
// not taken, so stalls lose and repeat nothing. Reset clears the valid bits only.
module fast_float_square_root_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_root_bits
);
   logic en;
   logic [ffsr_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [31:0] half, res;
   logic [31:0] x0_ff [2];
   logic [31:0] y0_ff [2];
   ffsr_pkg::lane_type l0, l1, l2, l3;

   // The pipeline moves whenever the last stage is empty or being taken.
   assign en = !vld_ff[ffsr_pkg::PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = en;

   ffsr_fmul u_half (.clock(clock), .en(en), .a(req_value_bits),
                     .b(ffsr_pkg::ONE_HALF), .p(half));

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff[0] <= req_value_bits;
         x0_ff[1] <= x0_ff[0];
         // Seed: magic minus arithmetic right shift of the raw bits.
         y0_ff[0] <= ffsr_pkg::SEED_MAGIC - {req_value_bits[31], req_value_bits[31:1]};
         y0_ff[1] <= y0_ff[0];
      end
   end

   assign l0.x = x0_ff[1];
   assign l0.half = half;
   assign l0.y = y0_ff[1];

   ffsr_newton u_n0 (.clock(clock), .en(en), .lane_i(l0), .lane_o(l1));
   ffsr_newton u_n1 (.clock(clock), .en(en), .lane_i(l1), .lane_o(l2));
   ffsr_newton u_n2 (.clock(clock), .en(en), .lane_i(l2), .lane_o(l3));

   ffsr_fmul u_out (.clock(clock), .en(en), .a(l3.x), .b(l3.y), .p(res));

   always_comb begin
      vld_in = {vld_ff[ffsr_pkg::PIPE_DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[ffsr_pkg::PIPE_DEPTH-1];
   // The multiplier already gives the canonical NaN for any NaN result.
   assign rsp_root_bits = ((res[30:23] == 8'hff) && (res[22:0] != 23'd0)) ?
                          ffsr_pkg::CANON_NAN : res;
endmodule

// ===== tb/fast_float_square_root_core_tb.sv =====
// Testbench for fast_float_square_root_core: random and directed binary32 requests checked
// against a bit-exact integer model of the seeded Newton square root.
// Depends on ffsr_pkg and the core itself.
module fast_float_square_root_core_tb;

   localparam int NUM_RANDOM = 700;
   localparam int CALM_TAIL  = 120;   // requests at the end, during which no new idle bursts start

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_value_bits = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_root_bits;

   logic [31:0] pending_values[$];   // requests not yet presented to the core
   logic [31:0] expected_roots[$];   // predicted roots, oldest first
   int          error_count = 0;
   bit          req_taken = 1'b0;    // set at the rising edge when a request was accepted
   bit          stim_done = 1'b0;
   int          req_idle_left = 0;
   int          rsp_stall_left = 0;

   fast_float_square_root_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value_bits (req_value_bits),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_root_bits  (rsp_root_bits)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bit-exact binary32 arithmetic, round to nearest even, subnormals kept.
   // Any NaN is produced as the canonical quiet NaN; the core only reports
   // the canonical pattern, so payload tracking is not needed.
   // ---------------------------------------------------------------------
   function automatic bit f32_is_nan(input logic [31:0] v);
      return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
   endfunction

   // Rounds the exact value m * 2^e to the nearest binary32 number.
   function automatic logic [31:0] round_to_single(input logic s, input int e,
                                                  input logic [127:0] m);
      int p;
      int lsb;
      int sh;
      int biased;
      logic [127:0] kept;
      logic g;
      logic st;
      if (m == 128'd0) return {s, 31'd0};
      p = 0;
      for (int i = 0; i < 128; i++) if (m[i]) p = i;
      // The lowest kept bit sits 23 below the leading one, but never below 2^-149.
      lsb = (p + e < -126) ? -149 : p + e - 23;
      sh = lsb - e;
      if (sh <= 0) begin
         kept = m << (-sh);
         g = 1'b0;
         st = 1'b0;
      end else if (sh > 128) begin
         kept = 128'd0;
         g = 1'b0;
         st = 1'b1;
      end else begin
         kept = m >> sh;
         g = m[sh-1];
         st = (m & ((128'd1 << (sh - 1)) - 128'd1)) != 128'd0;
      end
      if (g && (st || kept[0])) kept = kept + 128'd1;
      if (kept == 128'h1000000) begin
         kept = 128'h800000;
         lsb = lsb + 1;
      end
      if (kept >= 128'h800000) begin
         biased = lsb + 150;
         if (biased >= 255) return {s, 8'hff, 23'd0};
         return {s, 8'(biased), kept[22:0]};
      end
      return {s, 8'd0, kept[22:0]};
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
      logic s;
      logic [127:0] ma;
      logic [127:0] mb;
      int ea;
      int eb;
      s = a[31] ^ b[31];
      if (f32_is_nan(a) || f32_is_nan(b)) return ffsr_pkg::CANON_NAN;
      if (a[30:23] == 8'hff || b[30:23] == 8'hff) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return ffsr_pkg::CANON_NAN;
         return {s, 8'hff, 23'd0};
      end
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
      ma = {104'd0, a[30:23] != 8'd0, a[22:0]};
      mb = {104'd0, b[30:23] != 8'd0, b[22:0]};
      ea = (a[30:23] != 8'd0) ? int'(a[30:23]) - 150 : -149;
      eb = (b[30:23] != 8'd0) ? int'(b[30:23]) - 150 : -149;
      return round_to_single(s, ea + eb, ma * mb);
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] t;
      logic [127:0] ma;
      logic [127:0] mb;
      int ea;
      int eb;
      int d;
      if (f32_is_nan(a) || f32_is_nan(b)) return ffsr_pkg::CANON_NAN;
      if (a[30:23] == 8'hff && b[30:23] == 8'hff && a[31] != b[31])
         return ffsr_pkg::CANON_NAN;
      if (a[30:23] == 8'hff) return a;
      if (b[30:23] == 8'hff) return b;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 31'd0) return b;
      if (b[30:0] == 31'd0) return a;
      if (b[30:23] > a[30:23]) begin
         t = a;
         a = b;
         b = t;
      end
      ma = {104'd0, a[30:23] != 8'd0, a[22:0]};
      mb = {104'd0, b[30:23] != 8'd0, b[22:0]};
      ea = (a[30:23] != 8'd0) ? int'(a[30:23]) - 150 : -149;
      eb = (b[30:23] != 8'd0) ? int'(b[30:23]) - 150 : -149;
      d = ea - eb;
      // Give the larger operand 40 guard bits; anything the smaller one loses
      // beyond that only matters as a sticky bit.
      ma = ma << 40;
      if (d <= 40) begin
         mb = mb << (40 - d);
      end else if (d - 40 >= 64) begin
         mb = 128'd1;
      end else begin
         mb = (mb >> (d - 40)) |
              {127'd0, (mb & ((128'd1 << (d - 40)) - 128'd1)) != 128'd0};
      end
      if (a[31] == b[31]) return round_to_single(a[31], ea - 40, ma + mb);
      if (ma > mb) return round_to_single(a[31], ea - 40, ma - mb);
      if (mb > ma) return round_to_single(b[31], ea - 40, mb - ma);
      return 32'd0;
   endfunction

   // Seed from the bit pattern, three Newton steps, then x * y.
   function automatic logic [31:0] predict_root(input logic [31:0] x);
      logic [31:0] half;
      logic [31:0] y;
      logic [31:0] res;
      half = f32_mul(x, ffsr_pkg::ONE_HALF);
      y = ffsr_pkg::SEED_MAGIC - {x[31], x[31:1]};
      for (int k = 0; k < 3; k++)
         y = f32_mul(y, f32_add(ffsr_pkg::THREE_HALF,
                                f32_mul(f32_mul(half, y), y) ^ 32'h80000000));
      res = f32_mul(x, y);
      if (f32_is_nan(res)) res = ffsr_pkg::CANON_NAN;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver. It runs on the falling edge, so every input is stable
   // well before the rising edge that samples it. A request stays on the
   // bus until the monitor has seen it accepted.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_idle_left > 0) begin
            req_idle_left <= req_idle_left - 1;
            req_valid <= 1'b0;
         end else if (pending_values.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            // Start an idle burst on the request side.
            req_idle_left <= $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else if (pending_values.size() > 0) begin
            req_valid <= 1'b1;
            req_value_bits <= pending_values.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      // The result side stalls in bursts too, except near the end of the run.
      if (!reset) begin
         if (rsp_stall_left > 0) begin
            rsp_stall_left <= rsp_stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (pending_values.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            rsp_stall_left <= $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor. Accepted requests are predicted at once; each result taken
   // from the core is compared with the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            expected_roots.push_back(predict_root(req_value_bits));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_roots.size() == 0) begin
               $error("root_bits: expected nothing, actual %h", rsp_root_bits);
               error_count++;
            end else begin
               if (rsp_root_bits !== expected_roots[0]) begin
                  $error("root_bits: expected %h, actual %h",
                         expected_roots[0], rsp_root_bits);
                  error_count++;
               end
               void'(expected_roots.pop_front());
            end
         end
      end
   end

   // Random operand with the exponent field drawn from classes that matter.
   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(0, 9))
         0, 1, 2: ;                                          // any pattern at all
         3, 4, 5: v[31:23] = {1'b0, 8'($urandom_range(1, 254))}; // positive normal
         6:       v[30:23] = 8'd0;                           // subnormal or zero
         7:       v[30:23] = 8'hff;                          // infinity or NaN
         8:       v[30:23] = 8'($urandom_range(100, 154));   // near one, either sign
         default: v[31:23] = {1'b0, 8'($urandom_range(240, 254))}; // very large
      endcase
      return v;
   endfunction

   initial begin
      logic [31:0] directed[$];
      directed = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
                   32'h7fc00000, 32'h7f800001, 32'hffc00001, 32'hffffffff,
                   32'h00000001, 32'h80000001, 32'h007fffff, 32'h00800000,
                   32'h7f7fffff, 32'hff7fffff, 32'h3f800000, 32'h40800000,
                   32'hbf800000, 32'h3e800000, 32'h40000000, 32'h42c80000,
                   32'h7f000000, 32'h00400000, 32'hc0000000, 32'h55555555,
                   32'haaaaaaaa};
      foreach (directed[i]) pending_values.push_back(directed[i]);
      for (int i = 0; i < NUM_RANDOM; i++) pending_values.push_back(random_operand());

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pending_values.size() == 0 && !req_valid && expected_roots.size() == 0);
      // Give a stray extra result time to show up.
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_roots.size() == 0)
         $display("** fast_float_square_root_core: PASSED **");
      else
         $display("** fast_float_square_root_core: FAILED **");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("** fast_float_square_root_core: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ffsr_pkg.sv
sv/ffsr_fmul.sv
sv/ffsr_fsub.sv
sv/ffsr_newton.sv
sv/fast_float_square_root_core.sv
tb/fast_float_square_root_core_tb.sv
